// ===== hdl/vpe_pkg.sv =====
// Shared types and constants for the voxel palette encoder.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package vpe_pkg;

  localparam int unsigned DEF_PALETTE_DEPTH = 256;
  localparam int unsigned DEF_MAX_AXIS      = 255;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned POS_W             = 8;
  localparam int unsigned ID_W              = 15;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic STATUS_CELL  = 1'b0;
  localparam logic STATUS_ABORT = 1'b1;

  typedef struct packed {
    logic signed [15:0] block_id;
    logic               start_selection;
  } vpe_in_t;

  typedef struct packed {
    logic [7:0]      local_x;
    logic [7:0]      local_y;
    logic [7:0]      local_z;
    logic [7:0]      palette_index;
    logic            new_entry;
    logic [ID_W-1:0] entry_block_id;
    logic            status;
  } vpe_out_t;

  // one queued work unit from front to back
  typedef struct packed {
    logic             start;
    logic             voxel;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [ID_W-1:0]  id;
  } vpe_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_EMIT
  } vpe_bk_state_t;

endpackage

`default_nettype wire

// ===== hdl/vpe_front.sv =====
// Front end: accepts input transactions, tracks the box position and
// completion, drops empty ids and queues work for the back end. Uses vpe_pkg.
`default_nettype none

module vpe_front import vpe_pkg::*; #(
  parameter int unsigned MAX_AXIS = DEF_MAX_AXIS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire vpe_in_t               in_data,
  input  wire logic [CFG_DATA_W-1:0] size_x,
  input  wire logic [CFG_DATA_W-1:0] size_y,
  input  wire logic [CFG_DATA_W-1:0] size_z,
  output logic                       q_push,
  output vpe_entry_t                 q_entry,
  input  wire logic                  q_full
);

  localparam int unsigned AXIS_CAP = (MAX_AXIS > 255) ? 255 : MAX_AXIS;
  localparam logic [POS_W-1:0] CAP = POS_W'(AXIS_CAP);

  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
  logic             done, done_next;

  logic             accept, start, run, id_ok;
  logic [POS_W-1:0] px, py, pz;
  logic [POS_W-1:0] ext_x, ext_y, ext_z;
  logic [POS_W:0]   x1, y1, z1;

  function automatic logic [POS_W-1:0] extent(input logic [POS_W-1:0] r,
                                               input logic [POS_W-1:0] cap);
    logic [POS_W-1:0] e;
    e = (r == '0) ? POS_W'(1) : r;
    return (e > cap) ? cap : e;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign start    = in_data.start_selection;
  assign run      = start || !done;
  // strictly positive ids only
  assign id_ok    = !in_data.block_id[15] && (in_data.block_id != '0);

  assign ext_x = extent(size_x, CAP);
  assign ext_y = extent(size_y, CAP);
  assign ext_z = extent(size_z, CAP);

  assign px = start ? '0 : pos_x;
  assign py = start ? '0 : pos_y;
  assign pz = start ? '0 : pos_z;

  assign x1 = {1'b0, px} + (POS_W+1)'(1);
  assign z1 = {1'b0, pz} + (POS_W+1)'(1);
  assign y1 = {1'b0, py} + (POS_W+1)'(1);

  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    done_next  = done;
    if (accept && run) begin
      done_next  = 1'b0;
      pos_x_next = px;
      pos_y_next = py;
      pos_z_next = pz;
      if (x1 >= {1'b0, ext_x}) begin
        pos_x_next = '0;
        if (z1 >= {1'b0, ext_z}) begin
          pos_z_next = '0;
          if (y1 >= {1'b0, ext_y}) begin
            pos_y_next = '0;
            done_next  = 1'b1;
          end else begin
            pos_y_next = y1[POS_W-1:0];
          end
        end else begin
          pos_z_next = z1[POS_W-1:0];
        end
      end else begin
        pos_x_next = x1[POS_W-1:0];
      end
    end
  end

  // a start must reach the back end even when its id is empty
  always_comb begin
    q_entry.start = start;
    q_entry.voxel = run && id_ok;
    q_entry.x     = px;
    q_entry.y     = py;
    q_entry.z     = pz;
    q_entry.id    = in_data.block_id[ID_W-1:0];
    q_push        = accept && (start || (run && id_ok));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      done  <= 1'b0;
    end else begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
      done  <= done_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vpe_fifo.sv =====
// Short queue of work entries between the front and back ends.
// Uses vpe_pkg for the entry type and depth.
`default_nettype none

module vpe_fifo import vpe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire vpe_entry_t push_data,
  output logic            full,
  input  wire logic       pop,
  output vpe_entry_t      pop_data,
  output logic            empty
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  vpe_entry_t       slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full     = (fill == CNT_W'(FIFO_DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vpe_back.sv =====
// Back end: palette memory, sequential lookup over stored entries, append,
// abort on a full palette and the output register. Uses vpe_pkg.
`default_nettype none

module vpe_back import vpe_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire vpe_entry_t q_entry,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output vpe_out_t        out_data
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

  logic [ID_W-1:0]  palette_ids [PALETTE_DEPTH];

  vpe_bk_state_t    state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             aborted, aborted_next;
  vpe_entry_t       cur;
  logic [IDX_W-1:0] scan, scan_next;
  logic [IDX_W-1:0] rd_addr, rd_idx;
  logic [ID_W-1:0]  rd_data;
  logic             p_hit, p_hit_next;
  logic [IDX_W-1:0] p_idx, p_idx_next;

  logic             out_free, full, hit, last, go, load, wr_en;
  logic [CNT_W-1:0] count_eff;
  logic             aborted_eff;

  assign out_free    = !out_valid || !out_stall;
  assign full        = (count == CNT_W'(PALETTE_DEPTH));
  assign hit         = (rd_data == cur.id);
  assign last        = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign count_eff   = q_entry.start ? '0 : count;
  assign aborted_eff = q_entry.start ? 1'b0 : aborted;
  assign go          = q_entry.voxel && !aborted_eff;
  assign q_pop       = (state == BK_IDLE) && !q_empty;
  assign load        = (state == BK_EMIT) && out_free;
  assign wr_en       = load && !p_hit && !full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && go) begin
          state_next = (count_eff == '0) ? BK_EMIT : BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (hit || last) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    count_next   = count;
    aborted_next = aborted;
    scan_next    = scan;
    rd_addr      = scan;
    p_hit_next   = p_hit;
    p_idx_next   = p_idx;
    unique case (state)
      BK_IDLE: begin
        rd_addr    = '0;
        scan_next  = IDX_W'(1);
        p_hit_next = 1'b0;
        if (!q_empty) begin
          count_next   = count_eff;
          aborted_next = aborted_eff;
        end
      end
      BK_SEARCH: begin
        scan_next = scan + IDX_W'(1);
        if (hit) begin
          p_hit_next = 1'b1;
          p_idx_next = rd_idx;
        end
      end
      BK_EMIT: begin
        if (load) begin
          if (p_hit) begin
            count_next = count;
          end else if (full) begin
            aborted_next = 1'b1;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= palette_ids[rd_addr];
    if (wr_en) begin
      palette_ids[count[IDX_W-1:0]] <= cur.id;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    scan   <= scan_next;
    p_hit  <= p_hit_next;
    p_idx  <= p_idx_next;
    if (q_pop) begin
      cur <= q_entry;
    end
    if (load) begin
      if (!p_hit && full) begin
        out_data.local_x        <= '0;
        out_data.local_y        <= '0;
        out_data.local_z        <= '0;
        out_data.palette_index  <= '0;
        out_data.new_entry      <= 1'b0;
        out_data.entry_block_id <= '0;
        out_data.status         <= STATUS_ABORT;
      end else begin
        out_data.local_x        <= cur.x;
        out_data.local_y        <= cur.y;
        out_data.local_z        <= cur.z;
        out_data.palette_index  <= p_hit ? 8'(p_idx) : 8'(count);
        out_data.new_entry      <= !p_hit;
        out_data.entry_block_id <= cur.id;
        out_data.status         <= STATUS_CELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      aborted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      aborted <= aborted_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(PALETTE_DEPTH))
    else $error("palette count beyond depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_SEARCH |-> CNT_W'(rd_idx) < count)
    else $error("lookup read past filled entries");

  a_abort_sets: assert property (@(posedge clk) disable iff (rst)
    load && !p_hit && full |=> aborted && out_valid && out_data.status == STATUS_ABORT)
    else $error("full palette did not abort");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow palette");

endmodule

`default_nettype wire

// ===== hdl/voxel_palette_encoder.sv =====
// Voxel palette encoder. Front end takes one transaction per cycle into a
// 4-entry queue while it is not full; back end scans the palette memory one
// entry per cycle. A cell result holds the back end, which takes no new entry
// while it reads entries until a match (all filled entries on a miss); empty
// ids without a start never reach it. Reset (rst, synchronous) clears positions,
// palette count and modes and sets sizes to 1; palette contents are kept.
`default_nettype none

module voxel_palette_encoder import vpe_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int unsigned MAX_AXIS      = DEF_MAX_AXIS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire vpe_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output vpe_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] size_x, size_y, size_z;
  logic                  q_push, q_full, q_pop, q_empty;
  vpe_entry_t            q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= CFG_DATA_W'(1);
      size_y <= CFG_DATA_W'(1);
      size_z <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data;
        default:    ;
      endcase
    end
  end

  vpe_front #(
    .MAX_AXIS (MAX_AXIS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .size_x   (size_x),
    .size_y   (size_y),
    .size_z   (size_z),
    .q_push   (q_push),
    .q_entry  (q_in),
    .q_full   (q_full)
  );

  vpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  vpe_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_entry   (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
